[rtl/two_tone_wavetable_synth_with_avg_volume_defines.svh]
// Assertion macros shared by the synthesizer RTL.
`ifndef TWO_TONE_WAVETABLE_SYNTH_WITH_AVG_VOLUME_DEFINES_SVH
`define TWO_TONE_WAVETABLE_SYNTH_WITH_AVG_VOLUME_DEFINES_SVH

// implication or plain property, checked outside reset
`define TTWS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// condition that must never be seen outside reset
`define TTWS_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

[rtl/ttws_pkg.sv]
// Shared types, constants and table helper for the two-tone synthesizer.
package ttws_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int STEP_W      = 26;
  localparam int FRAC_W      = 16;
  localparam int SINE_W      = 16;
  localparam int SCALE_SHIFT = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DEPTH   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_A_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TONE_B_STEP = CFG_IDX_W'(1);

  typedef enum logic {
    REQ_VOLUME = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  localparam logic [SAMPLE_W-1:0] START_VOLUME = 12'd2048;
  localparam logic [SAMPLE_W-1:0] DAC_OFFSET   = 12'd2048;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_PEAK   = 64'd32767;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } vol_req_t;

  // 32767*sin(x) for x in Q30 radians, 0..pi/2; elaboration only
  function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    t  = (t * x) >> 30;
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    return SINE_W'((t * SINE_PEAK) >> 30);
  endfunction

endpackage

[rtl/ttws_avg.sv]
// Volume averager: sample ring in memory, running sum, divide by ring depth.
`include "two_tone_wavetable_synth_with_avg_volume_defines.svh"

module ttws_avg #(
  parameter int AVG_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ttws_pkg::vol_req_t               req,
  output logic [ttws_pkg::SAMPLE_W-1:0]    volume
);

  localparam int SW    = ttws_pkg::SAMPLE_W;
  localparam int POS_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = SW + POS_W;
  localparam int QD_W  = SUM_W + POS_W + 1;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / AVG_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(AVG_DEPTH - 1);
  localparam logic [QD_W-1:0] DEPTH_QD = QD_W'(AVG_DEPTH);

  logic [SW-1:0]        ring_mem [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] ring_vld;
  logic [POS_W-1:0]     pos;

  logic                 s1_vld;
  logic [POS_W-1:0]     s1_pos;
  logic [SW-1:0]        s1_sample;
  logic [SW-1:0]        old_rd;
  logic                 old_vld;
  logic [SUM_W-1:0]     ring_sum;
  logic                 s2_vld;
  logic                 s3_vld;
  logic [SUM_W-1:0]     s3_sum;
  logic [SUM_W-1:0]     s3_q;

  logic [SW-1:0]        old_val;
  logic [SUM_W-1:0]     sum_next;
  logic [2*SUM_W-1:0]   recip_prod;
  logic [QD_W-1:0]      rem;

  assign old_val    = old_vld ? old_rd : '0;
  assign sum_next   = ring_sum - SUM_W'(old_val) + SUM_W'(s1_sample);
  assign recip_prod = (2*SUM_W)'(ring_sum) * (2*SUM_W)'(RECIP);
  assign rem        = QD_W'(s3_sum) - QD_W'(s3_q) * DEPTH_QD;

  always_ff @(posedge clk) begin
    if (req.valid) begin
      old_rd <= ring_mem[pos];
    end
    if (s1_vld) begin
      ring_mem[s1_pos] <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos    <= pos;
    s1_sample <= req.sample;
    s3_sum    <= ring_sum;
    s3_q      <= SUM_W'(recip_prod >> SUM_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      pos      <= '0;
      s1_vld   <= 1'b0;
      old_vld  <= 1'b0;
      ring_sum <= '0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      volume   <= ttws_pkg::START_VOLUME;
    end else begin
      s1_vld <= req.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      if (req.valid) begin
        old_vld <= ring_vld[pos];
        pos     <= (pos == LAST_POS) ? '0 : pos + POS_W'(1);
      end
      if (s1_vld) begin
        ring_vld[s1_pos] <= 1'b1;
        ring_sum         <= sum_next;
      end
      if (s3_vld) begin
        volume <= SW'((rem >= DEPTH_QD) ? s3_q + SUM_W'(1) : s3_q);
      end
    end
  end

  `TTWS_ASSERT(a_rem_bound, clk, rst, s3_vld |-> (rem < (DEPTH_QD << 1)), "quotient estimate off by more than one")
  `TTWS_NEVER(a_sum_underflow, clk, rst, s1_vld && (ring_sum < SUM_W'(old_val)), "running sum below evicted sample")

endmodule

[rtl/two_tone_wavetable_synth_with_avg_volume.sv]
// Two-tone wavetable synthesizer: top level with phase, table, scaling, output queue.
// A tick passes phase, table, tone sum and product registers, then the output queue.
// Throughput: one word per cycle; volume words give no result and use the same slot.
// A config write blocks input while the step is reduced mod the table span.
// Input also stalls when the 8-entry output queue plus ticks in flight is full.
// Reset (sync, high): phases and steps zero, volume 2048, ring valid bits cleared.
`include "two_tone_wavetable_synth_with_avg_volume_defines.svh"

module two_tone_wavetable_synth_with_avg_volume #(
  parameter int TABLE_DEPTH = 1000,
  parameter int AVG_DEPTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttws_pkg::STEP_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [ttws_pkg::SAMPLE_W-1:0]     volume_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttws_pkg::SAMPLE_W-1:0]     dac_value
);

  localparam int SW      = ttws_pkg::SAMPLE_W;
  localparam int FW      = ttws_pkg::FRAC_W;
  localparam int SNW     = ttws_pkg::SINE_W;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = IDX_W + FW;
  localparam int HI_W    = ttws_pkg::STEP_W - FW;
  localparam int MW      = HI_W + IDX_W + 1;
  localparam int PROD_W  = SNW + SW + 2;
  localparam int QD      = ttws_pkg::OUT_DEPTH;
  localparam int PTR_W   = $clog2(QD);
  localparam int CNT_W   = PTR_W + 1;
  localparam logic [PHASE_W:0] PHASE_LIM = (PHASE_W+1)'(longint'(TABLE_DEPTH) << FW);
  localparam logic [HI_W:0]    STEP_RECIP = (HI_W+1)'((2 ** HI_W) / TABLE_DEPTH);
  localparam logic [MW-1:0]    DEPTH_M = MW'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] QD_CNT = CNT_W'(QD);

  // sine table, one full period
  logic signed [SNW-1:0] sine_rom [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned A4   = 64'(4 * g);
    localparam longint unsigned QUAD = A4 / TABLE_DEPTH;
    localparam longint unsigned REM  = A4 % TABLE_DEPTH;
    localparam longint unsigned NUM  = (QUAD % 2 == 1) ? TABLE_DEPTH - REM : REM;
    localparam longint unsigned XQ   = (NUM * ttws_pkg::HALF_PI_Q30) / TABLE_DEPTH;
    localparam logic [SNW-1:0] MAG = (REM == 0) ?
        ((QUAD % 2 == 1) ? SNW'(ttws_pkg::SINE_PEAK) : '0) : ttws_pkg::quarter_sine(XQ);
    localparam logic [SNW-1:0] VAL = (QUAD >= 2) ? SNW'(-MAG) : MAG;
    assign sine_rom[g] = VAL;
  end

  // config: step reduced modulo the table span over one register stage
  logic                           cfg1_vld;
  logic [ttws_pkg::CFG_IDX_W-1:0] cfg1_idx;
  logic [FW-1:0]                  cfg1_lo;
  logic [HI_W-1:0]                cfg1_hi;
  logic [HI_W-1:0]                cfg1_q;
  logic                           cfg1_zero;
  logic [2*HI_W:0]                step_p;
  logic [MW-1:0]                  step_rem;
  logic [MW-1:0]                  step_rem_c;
  logic [PHASE_W-1:0]             step_red;

  assign cfg_ready  = 1'b1;
  assign step_p     = (2*HI_W+1)'(cfg_data[ttws_pkg::STEP_W-1:FW]) * (2*HI_W+1)'(STEP_RECIP);
  assign step_rem   = MW'(cfg1_hi) - MW'(cfg1_q) * DEPTH_M;
  assign step_rem_c = (step_rem >= DEPTH_M) ? step_rem - DEPTH_M : step_rem;
  assign step_red   = {IDX_W'(step_rem_c), cfg1_lo};

  always_ff @(posedge clk) begin
    cfg1_idx  <= cfg_index;
    cfg1_lo   <= cfg_data[FW-1:0];
    cfg1_hi   <= cfg_data[ttws_pkg::STEP_W-1:FW];
    cfg1_q    <= HI_W'(step_p >> HI_W);
    cfg1_zero <= (cfg_data == '0);
  end

  // input side
  logic             in_acc;
  logic             tick_acc;
  logic             out_acc;
  logic [CNT_W-1:0] credits;
  ttws_pkg::vol_req_t vol_req;
  logic [SW-1:0]    volume;

  assign in_ready = (credits < QD_CNT) && !cfg1_vld;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (req_type == ttws_pkg::REQ_TICK);
  assign out_acc  = out_valid && out_ready;

  assign vol_req.valid  = in_acc && (req_type == ttws_pkg::REQ_VOLUME);
  assign vol_req.sample = volume_sample;

  ttws_avg #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_avg (
    .clk    (clk),
    .rst    (rst),
    .req    (vol_req),
    .volume (volume)
  );

  // phase accumulators
  logic [PHASE_W-1:0] step_a;
  logic [PHASE_W-1:0] step_b;
  logic [PHASE_W-1:0] phase_a;
  logic [PHASE_W-1:0] phase_b;
  logic [PHASE_W:0]   sum_a;
  logic [PHASE_W:0]   sum_b;
  logic [PHASE_W-1:0] phase_a_next;
  logic [PHASE_W-1:0] phase_b_next;

  always_comb begin
    sum_a        = (PHASE_W+1)'(phase_a) + (PHASE_W+1)'(step_a);
    sum_b        = (PHASE_W+1)'(phase_b) + (PHASE_W+1)'(step_b);
    phase_a_next = PHASE_W'((sum_a >= PHASE_LIM) ? sum_a - PHASE_LIM : sum_a);
    phase_b_next = PHASE_W'((sum_b >= PHASE_LIM) ? sum_b - PHASE_LIM : sum_b);
  end

  // tick pipeline
  logic                     p1_vld;
  logic                     p2_vld;
  logic                     p3_vld;
  logic                     p4_vld;
  logic signed [SNW-1:0]    rom_a;
  logic signed [SNW-1:0]    rom_b;
  logic signed [SNW:0]      tone_sum;
  logic signed [PROD_W-1:0] prod;
  logic [SW-1:0]            dac_w;

  assign dac_w = prod[ttws_pkg::SCALE_SHIFT +: SW] + ttws_pkg::DAC_OFFSET;

  always_ff @(posedge clk) begin
    rom_a    <= sine_rom[phase_a[PHASE_W-1:FW]];
    rom_b    <= sine_rom[phase_b[PHASE_W-1:FW]];
    tone_sum <= (SNW+1)'(rom_a) + (SNW+1)'(rom_b);
    prod     <= PROD_W'(tone_sum) * PROD_W'($signed({1'b0, volume}));
  end

  // output queue
  logic [SW-1:0]    fifo_mem [QD];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fifo_cnt;

  always_ff @(posedge clk) begin
    if (p4_vld) begin
      fifo_mem[wr_ptr] <= dac_w;
    end
  end

  assign out_valid = (fifo_cnt != '0);
  assign dac_value = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg1_vld <= 1'b0;
      step_a   <= '0;
      step_b   <= '0;
      phase_a  <= '0;
      phase_b  <= '0;
      p1_vld   <= 1'b0;
      p2_vld   <= 1'b0;
      p3_vld   <= 1'b0;
      p4_vld   <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      credits  <= '0;
    end else begin
      cfg1_vld <= cfg_valid && cfg_ready;
      p1_vld   <= tick_acc;
      p2_vld   <= p1_vld;
      p3_vld   <= p2_vld;
      p4_vld   <= p3_vld;
      if (cfg1_vld && (cfg1_idx == ttws_pkg::REG_TONE_A_STEP)) begin
        step_a <= step_red;
        if (cfg1_zero) begin
          phase_a <= '0;
        end
      end else if (tick_acc) begin
        phase_a <= phase_a_next;
      end
      if (cfg1_vld && (cfg1_idx == ttws_pkg::REG_TONE_B_STEP)) begin
        step_b <= step_red;
        if (cfg1_zero) begin
          phase_b <= '0;
        end
      end else if (tick_acc) begin
        phase_b <= phase_b_next;
      end
      if (p4_vld) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_W'(p4_vld) - CNT_W'(out_acc);
      credits  <= credits + CNT_W'(tick_acc) - CNT_W'(out_acc);
    end
  end

  `TTWS_ASSERT(a_tick_reaches_queue, clk, rst, tick_acc |-> ##4 p4_vld, "tick lost in pipeline")
  `TTWS_ASSERT(a_queue_within_credit, clk, rst, fifo_cnt <= credits, "queue holds more words than credited")
  `TTWS_ASSERT(a_phase_range, clk, rst, ({1'b0, phase_a} < PHASE_LIM) && ({1'b0, phase_b} < PHASE_LIM), "phase beyond table span")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the two-tone wavetable synthesizer with averaged volume.
`timescale 1ns / 100ps

module testbench;

  localparam int TAB_DEPTH = 1000;
  localparam int RING_DEPTH = 32;
  localparam bit [31:0] PHASE_SPAN = TAB_DEPTH * 65536;
  localparam bit [25:0] STEP_TOP = 26'd65535999;
  localparam bit [25:0] STEP_ALL_ONES = 26'h3FFFFFF;
  localparam bit [25:0] QUARTER_STEP = 26'(250 * 65536);
  localparam logic [ttws_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = ttws_pkg::CFG_IDX_W'(2);
  localparam logic [ttws_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = ttws_pkg::CFG_IDX_W'(3);
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned QUARTER_PI_SPAN_Q30 = 64'd1686629713;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 8;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [ttws_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [ttws_pkg::STEP_W-1:0]        cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               req_type = 1'b0;
  logic [ttws_pkg::SAMPLE_W-1:0]      volume_sample = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [ttws_pkg::SAMPLE_W-1:0]      dac_value;

  // model state
  int          sine_tab [TAB_DEPTH];
  bit [25:0]   tone_a_inc, tone_b_inc;
  bit [31:0]   tone_a_phase, tone_b_phase;
  bit [11:0]   vol_ring [RING_DEPTH];
  int          vol_sum;
  int          vol_pos;
  bit [11:0]   volume_level = ttws_pkg::START_VOLUME;

  logic [ttws_pkg::SAMPLE_W-1:0] dac_pending_q [$];
  int fault_count = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  two_tone_wavetable_synth_with_avg_volume u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .volume_sample(volume_sample),
    .out_valid(out_valid), .out_ready(out_ready), .dac_value(dac_value)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // 32767*sin of num/TAB_DEPTH quarter turns, Taylor series in Q30
  function automatic int sine_mag(int unsigned num);
    longint unsigned x, x2, t, d;
    x = (longint'(num) * QUARTER_PI_SPAN_Q30) / TAB_DEPTH;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int n = 6; n >= 1; n--) begin
      d = (2 * n) * (2 * n + 1);
      t = ONE_Q30 - ((x2 * t) >> 30) / d;
    end
    t = (t * x) >> 30;
    if (t > ONE_Q30) t = ONE_Q30;
    return int'((t * 64'd32767) >> 30);
  endfunction

  task automatic build_sine_tab();
    int unsigned quad, rem;
    int mag;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      quad = (4 * i) / TAB_DEPTH;
      rem = (4 * i) % TAB_DEPTH;
      if (quad[0]) mag = (rem == 0) ? 32767 : sine_mag(TAB_DEPTH - rem);
      else mag = (rem == 0) ? 0 : sine_mag(rem);
      sine_tab[i] = (quad >= 2) ? -mag : mag;
    end
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 28);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_dac
    logic [ttws_pkg::SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (dac_pending_q.size() == 0) begin
        $display("%0t dac_value: expected none, got %0d", $time, dac_value);
        fault_count++;
      end else begin
        want = dac_pending_q.pop_front();
        if (dac_value !== want) begin
          $display("%0t dac_value: expected %0d, got %0d", $time, want, dac_value);
          fault_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [ttws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ttws_pkg::STEP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ttws_pkg::REG_TONE_A_STEP) begin
      tone_a_inc = val;
      if (val == 0) tone_a_phase = 0;
    end else if (idx == ttws_pkg::REG_TONE_B_STEP) begin
      tone_b_inc = val;
      if (val == 0) tone_b_phase = 0;
    end
    @(posedge clk);
  endtask

  // offer one word, then advance the model once it is taken
  task automatic send_word(input ttws_pkg::req_type_t kind,
                           input logic [ttws_pkg::SAMPLE_W-1:0] smp);
    bit gapped;
    int mix;
    int scaled;
    gapped = 1'b0;
    while (!calm && $urandom_range(0, 99) < 28) begin
      if (!gapped) in_valid <= 1'b0;
      gapped = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    volume_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == ttws_pkg::REQ_VOLUME) begin
      vol_sum = vol_sum - int'(vol_ring[vol_pos]) + int'(smp);
      vol_ring[vol_pos] = smp;
      vol_pos = (vol_pos + 1) % RING_DEPTH;
      volume_level = 12'(vol_sum / RING_DEPTH);
    end else begin
      tone_a_phase = (tone_a_phase + 32'(tone_a_inc)) % PHASE_SPAN;
      tone_b_phase = (tone_b_phase + 32'(tone_b_inc)) % PHASE_SPAN;
      mix = sine_tab[tone_a_phase >> 16] + sine_tab[tone_b_phase >> 16];
      scaled = (mix * int'(volume_level)) >>> 17;
      dac_pending_q.push_back(12'(scaled + int'(ttws_pkg::DAC_OFFSET)));
    end
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (dac_pending_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [ttws_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 26'd1;
      2: return STEP_TOP;
      3: return STEP_ALL_ONES;
      4: return 26'($urandom_range(1, 1 << 20));
      5: return 26'($urandom_range(0, STEP_TOP));
      6: return 26'($urandom);
      default: return QUARTER_STEP;
    endcase
  endfunction

  task automatic send_ticks(input int count);
    repeat (count) send_word(ttws_pkg::REQ_TICK, 12'($urandom));
  endtask

  task automatic test_silent_start();
    send_ticks(2);
    send_word(ttws_pkg::REQ_VOLUME, 12'd0);
    send_word(ttws_pkg::REQ_VOLUME, 12'hFFF);
    send_ticks(2);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_quarter_points();
    write_reg(ttws_pkg::REG_TONE_A_STEP, QUARTER_STEP);
    write_reg(ttws_pkg::REG_TONE_B_STEP, QUARTER_STEP);
    send_ticks(5);
    drain(SETTLE_CYCLES);
    write_reg(ttws_pkg::REG_TONE_A_STEP, '0);
    send_ticks(2);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_step_extremes();
    write_reg(ttws_pkg::REG_TONE_A_STEP, STEP_TOP);
    write_reg(ttws_pkg::REG_TONE_B_STEP, STEP_ALL_ONES);
    write_reg(REG_SPARE_2, 26'($urandom));
    write_reg(REG_SPARE_3, STEP_ALL_ONES);
    send_ticks(4);
    send_word(ttws_pkg::REQ_VOLUME, 12'hAAA);
    send_word(ttws_pkg::REQ_VOLUME, 12'h555);
    send_ticks(2);
    drain(SETTLE_CYCLES);
    write_reg(ttws_pkg::REG_TONE_B_STEP, '0);
    write_reg(ttws_pkg::REG_TONE_A_STEP, 26'd1);
    send_ticks(2);
    drain(SETTLE_CYCLES);
  endtask

  // full volume drives the output to both rails
  task automatic test_full_scale();
    write_reg(ttws_pkg::REG_TONE_A_STEP, QUARTER_STEP);
    write_reg(ttws_pkg::REG_TONE_B_STEP, QUARTER_STEP);
    repeat (RING_DEPTH) send_word(ttws_pkg::REQ_VOLUME, 12'hFFF);
    send_ticks(4);
    repeat (RING_DEPTH) send_word(ttws_pkg::REQ_VOLUME, 12'h000);
    send_ticks(2);
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_output_stall();
    write_reg(ttws_pkg::REG_TONE_A_STEP, pick_step());
    write_reg(ttws_pkg::REG_TONE_B_STEP, pick_step());
    calm = 1'b1;
    hold_request = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_word(ttws_pkg::REQ_VOLUME, 12'($urandom));
      else send_ticks(1);
    end
    calm = 1'b0;
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (12) begin
        if ($urandom_range(0, 2) == 0) send_word(ttws_pkg::REQ_VOLUME, 12'($urandom));
        else send_ticks(1);
      end
      drain(0);
    end
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 3);
      write_reg(ttws_pkg::REG_TONE_A_STEP, pick_step());
      write_reg(ttws_pkg::REG_TONE_B_STEP, pick_step());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 26'($urandom));
      repeat (60) begin
        if ($urandom_range(0, 99) < 30) send_word(ttws_pkg::REQ_VOLUME, 12'($urandom));
        else send_ticks(1);
      end
      drain(SETTLE_CYCLES);
    end
    calm = 1'b0;
  endtask

  initial begin
    build_sine_tab();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_silent_start();
    test_quarter_points();
    test_step_extremes();
    test_full_scale();
    test_output_stall();
    test_drain_pause();
    test_random_mix();
    drain(20);
    if (fault_count == 0 && dac_pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[two_tone_wavetable_synth_with_avg_volume.f]
+incdir+rtl
rtl/ttws_pkg.sv
rtl/ttws_avg.sv
rtl/two_tone_wavetable_synth_with_avg_volume.sv
bench/testbench.sv
